@@ rtl/core/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256_pkg
// Request types and fixed SHA-256 constants for the digest engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int HASH_WORDS  = 8;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 64;

  // Byte count of a full message word
  localparam logic [2:0] FULL_WORD_BYTES = 3'd4;
  // First padding byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        final_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_item_t;

  localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

@@ rtl/core/sha256_digest_engine.sv @@
// A word that does not complete a block is taken without a stall; a word that
// completes a block keeps the input stalled while the 64 rounds run on one shared
// round unit and the result is then folded into the chaining state.
// A final word adds padding and one or two block compressions, then shows the
// eight digest words, held while out_stall is high; the input stays stalled meanwhile.
// Reset (rst, synchronous) returns to idle with the initial hash loaded and length zero.
// ----------------------------------------------------------------------------
// sha256_digest_engine
// SHA-256 over a stream of big-endian words with FIPS 180-4 padding, one
// compression round per cycle and a 16-word sliding schedule window.
// ----------------------------------------------------------------------------
module sha256_digest_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha256_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha256_pkg::out_item_t out_data
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMPRESS,
    S_FOLD,
    S_EMIT
  } state_t;

  localparam logic [3:0] FILL_LAST = 4'(BLOCK_WORDS - 1);
  localparam logic [3:0] FILL_LEN  = 4'(BLOCK_WORDS - 2);
  localparam logic [5:0] ROUND_LAST = 6'(ROUNDS - 1);
  localparam logic [2:0] EMIT_LAST  = 3'(HASH_WORDS - 1);

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  state_t      state;
  logic [31:0] chain [HASH_WORDS];
  logic [31:0] win [BLOCK_WORDS];
  logic [31:0] vars [HASH_WORDS];
  logic [3:0]  fill;
  logic [63:0] bits;
  logic [5:0]  round;
  logic [2:0]  emit_idx;
  logic        pend80;
  logic        hi_done;
  logic        padding;

  logic [2:0]  cnt_sat;
  logic [31:0] final_word_pad;
  logic        push_en;
  logic [31:0] push_word;
  logic [31:0] sched_word;
  logic [31:0] t1;
  logic [31:0] t2;
  logic        win_shift;
  logic [31:0] win_in;

  // Saturate the byte count
  assign cnt_sat = (in_data.byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES
                                                          : in_data.byte_count;

  // Mask trailing bytes of a short final word and place the pad byte
  always_comb begin
    case (cnt_sat)
      3'd0:    final_word_pad = {PAD_BYTE, 24'h0};
      3'd1:    final_word_pad = {in_data.message_word[31:24], PAD_BYTE, 16'h0};
      3'd2:    final_word_pad = {in_data.message_word[31:16], PAD_BYTE, 8'h0};
      3'd3:    final_word_pad = {in_data.message_word[31:8], PAD_BYTE};
      default: final_word_pad = in_data.message_word;
    endcase
  end

  // Select the word pushed into the block window
  always_comb begin
    push_en   = 1'b0;
    push_word = '0;
    if (state == S_IDLE && in_valid) begin
      push_en   = 1'b1;
      push_word = in_data.final_word ? final_word_pad : in_data.message_word;
    end else if (state == S_PAD) begin
      push_en = 1'b1;
      if (pend80) begin
        push_word = {PAD_BYTE, 24'h0};
      end else if (fill == FILL_LEN) begin
        push_word = bits[63:32];
      end else if (fill == FILL_LAST && hi_done) begin
        push_word = bits[31:0];
      end else begin
        push_word = '0;
      end
    end
  end

  // Shared round unit and schedule expansion
  assign sched_word = small_sig1(win[14]) + win[9] + small_sig0(win[1]) + win[0];
  assign t1 = vars[7] + big_sig1(vars[4]) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
            + ROUND_K[round] + win[0];
  assign t2 = big_sig0(vars[0])
            + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));

  assign win_shift = push_en || (state == S_COMPRESS);
  assign win_in    = push_en ? push_word : sched_word;

  // Shift the schedule window
  always_ff @(posedge clk) begin
    if (win_shift) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[BLOCK_WORDS - 1] <= win_in;
    end
  end

  // Sequencer: accept, pad, compress, fold and emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      bits     <= '0;
      round    <= '0;
      emit_idx <= '0;
      pend80   <= 1'b0;
      hi_done  <= 1'b0;
      padding  <= 1'b0;
      for (int i = 0; i < HASH_WORDS; i++) begin
        chain[i] <= INIT_HASH[i];
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.final_word) begin
              bits    <= bits + {58'b0, cnt_sat, 3'b000};
              padding <= 1'b1;
              pend80  <= (cnt_sat == FULL_WORD_BYTES);
              // A word that fills the block compresses first
              if (fill != FILL_LAST) begin
                state <= S_PAD;
              end
            end else begin
              bits <= bits + 64'd32;
            end
          end
        end
        S_PAD: begin
          if (pend80) begin
            pend80 <= 1'b0;
          end else if (fill == FILL_LEN) begin
            hi_done <= 1'b1;
          end
        end
        S_COMPRESS: begin
          vars[7] <= vars[6];
          vars[6] <= vars[5];
          vars[5] <= vars[4];
          vars[4] <= vars[3] + t1;
          vars[3] <= vars[2];
          vars[2] <= vars[1];
          vars[1] <= vars[0];
          vars[0] <= t1 + t2;
          round   <= round + 6'd1;
          if (round == ROUND_LAST) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          for (int i = 0; i < HASH_WORDS; i++) begin
            chain[i] <= chain[i] + vars[i];
          end
          if (hi_done) begin
            state <= S_EMIT;
          end else if (padding) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            // Rotate the digest out and refill with the initial hash
            for (int i = 0; i < HASH_WORDS - 1; i++) begin
              chain[i] <= chain[i + 1];
            end
            chain[HASH_WORDS - 1] <= INIT_HASH[emit_idx];
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == EMIT_LAST) begin
              bits    <= '0;
              padding <= 1'b0;
              hi_done <= 1'b0;
              state   <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      // Advance the fill count; a full block starts the rounds
      if (push_en) begin
        if (fill == FILL_LAST) begin
          fill  <= '0;
          round <= '0;
          for (int i = 0; i < HASH_WORDS; i++) begin
            vars[i] <= chain[i];
          end
          state <= S_COMPRESS;
        end else begin
          fill <= fill + 4'd1;
        end
      end
    end
  end

  assign in_stall             = (state != S_IDLE);
  assign out_valid            = (state == S_EMIT);
  assign out_data.digest_word = chain[0];
  assign out_data.digest_last = (emit_idx == EMIT_LAST);

endmodule

@@ rtl/core/sha256_chk.sv @@
// ----------------------------------------------------------------------------
// sha256_chk
// Port-level checks for the SHA-256 digest engine, bound to every engine instance.
// ----------------------------------------------------------------------------
module sha256_chk (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input sha256_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input sha256_pkg::out_item_t out_data
);
  import sha256_pkg::*;

  // Come out of reset idle: ready for a request, no digest shown
  a_reset_idle: assert property (@(posedge clk) rst |=> (!out_valid && !in_stall))
    else $error("engine not idle after reset");

  // Hold off requests while a digest is being shown
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted during digest output");

  // A final word always starts padding or a block compression, so the input stalls next
  a_final_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.final_word) |=> in_stall)
    else $error("input not stalled after final word");

  // Drop the output after the last digest word is taken
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.digest_last) |=> !out_valid)
    else $error("output continues after last digest word");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind sha256_digest_engine sha256_chk u_sha256_chk (.*);

@@ bench/sha256_digest_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the digest engine, hashes every accepted request
// with its own SHA-256 model and compares each digest word as it leaves.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  sha256_pkg::in_item_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  sha256_pkg::out_item_t out_data,
  output int                    fail_count,
  output int                    pending
);
  import sha256_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Model state: chaining hash, block being filled, running bit length
  logic [31:0]  hash_state [HASH_WORDS];
  logic [31:0]  blk_words [BLOCK_WORDS];
  int unsigned  blk_fill;
  logic [63:0]  msg_bit_len;
  out_item_t    digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run the 64 rounds over the current block and fold into the chaining hash
  function automatic void compress_blk();
    logic [31:0] sched [ROUNDS];
    logic [31:0] v [HASH_WORDS];
    logic [31:0] s0, s1, ch, maj, t1, t2;
    for (int j = 0; j < BLOCK_WORDS; j++) sched[j] = blk_words[j];
    for (int j = BLOCK_WORDS; j < ROUNDS; j++) begin
      s0 = rotr(sched[j-15], 7) ^ rotr(sched[j-15], 18) ^ (sched[j-15] >> 3);
      s1 = rotr(sched[j-2], 17) ^ rotr(sched[j-2], 19) ^ (sched[j-2] >> 10);
      sched[j] = s1 + sched[j-7] + s0 + sched[j-16];
    end
    for (int j = 0; j < HASH_WORDS; j++) v[j] = hash_state[j];
    for (int r = 0; r < ROUNDS; r++) begin
      s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1  = v[7] + s1 + ch + ROUND_K[r] + sched[r];
      s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2  = s0 + maj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int j = 0; j < HASH_WORDS; j++) hash_state[j] = hash_state[j] + v[j];
  endfunction

  function automatic void load_word(input logic [31:0] wd);
    blk_words[blk_fill] = wd;
    blk_fill++;
    if (blk_fill == BLOCK_WORDS) begin
      compress_blk();
      blk_fill = 0;
    end
  endfunction

  function automatic void restart_hash();
    for (int j = 0; j < HASH_WORDS; j++) hash_state[j] = INIT_HASH[j];
    blk_fill    = 0;
    msg_bit_len = '0;
  endfunction

  // Absorb one request; on a final word pad, finish and queue the digest
  function automatic void absorb_request(input in_item_t req);
    logic [2:0]  nbytes;
    logic [31:0] keep;
    out_item_t   dw;
    nbytes = (req.byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : req.byte_count;
    if (!req.final_word) begin
      msg_bit_len += 64'd32;
      load_word(req.message_word);
      return;
    end
    msg_bit_len += {58'd0, nbytes, 3'd0};
    if (nbytes == FULL_WORD_BYTES) begin
      load_word(req.message_word);
      load_word({PAD_BYTE, 24'd0});
    end else begin
      keep = (nbytes == 3'd0) ? 32'd0 : ~(32'hffffffff >> (8 * nbytes));
      load_word((req.message_word & keep) | ({24'd0, PAD_BYTE} << (24 - 8 * nbytes)));
    end
    // No room for the length: zero out this block and start another
    if (blk_fill > BLOCK_WORDS - 2) begin
      while (blk_fill != 0) load_word(32'd0);
    end
    while (blk_fill < BLOCK_WORDS - 2) load_word(32'd0);
    load_word(msg_bit_len[63:32]);
    load_word(msg_bit_len[31:0]);
    for (int j = 0; j < HASH_WORDS; j++) begin
      dw.digest_word = hash_state[j];
      dw.digest_last = (j == HASH_WORDS - 1);
      digest_q.push_back(dw);
    end
    restart_hash();
  endfunction

  function automatic void log_failure(input string msg);
    if (fail_count < REPORT_LIMIT) $display("%s", msg);
    fail_count++;
  endfunction

  // Sample both channels at the edge; predict first, then compare
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      restart_hash();
      digest_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) absorb_request(in_data);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          log_failure($sformatf("unexpected digest word %h last=%0b",
                                out_data.digest_word, out_data.digest_last));
        end else begin
          want = digest_q.pop_front();
          if (want.digest_word !== out_data.digest_word ||
              want.digest_last !== out_data.digest_last) begin
            log_failure($sformatf("digest mismatch: expected %h last=%0b, got %h last=%0b",
                                  want.digest_word, want.digest_last,
                                  out_data.digest_word, out_data.digest_last));
          end
        end
      end
    end
    pending = digest_q.size();
  end

endmodule

@@ bench/tb_sha256_digest_engine.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha256_digest_engine
// Feeds directed and random messages through the digest engine with bursty
// requests and a patterned output stall; the checker scores every digest.
// ----------------------------------------------------------------------------
module tb_sha256_digest_engine;
  import sha256_pkg::*;

  localparam int RANDOM_WORDS = 480;
  localparam int TAIL_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 300000;

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int burst_left  = 0;

  // Output stall pattern state
  int   stall_mode  = 0;
  int   mode_left   = 0;
  int   run_left    = 0;
  logic stall_level = 1'b0;

  sha256_digest_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sha256_digest_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Drive out_stall: free-flowing, random, or long stall runs, mode changes often
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 120);
    end
    mode_left--;
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        if (run_left == 0) begin
          stall_level = ~stall_level;
          run_left    = stall_level ? $urandom_range(4, 12) : $urandom_range(1, 6);
        end
        run_left--;
        out_stall <= stall_level;
      end
    endcase
  end

  // Send one request; open a new burst after a random gap when the last one ran out
  task automatic send_req(input logic [31:0] wd, input logic [2:0] nbytes, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= {wd, nbytes, fin};
    do @(posedge clk); while (in_stall);
  endtask

  // Full words (byte count now and then off four), then a final word
  task automatic send_message(input int full_words, input logic [2:0] tail_bytes);
    for (int i = 0; i < full_words; i++) begin
      send_req($urandom,
               ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : FULL_WORD_BYTES,
               1'b0);
    end
    send_req($urandom, tail_bytes, 1'b1);
  endtask

  initial begin
    int words_sent;
    int full_words;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty message, "abc", four-byte tail, saturated byte counts
    send_req(32'h00000000, 3'd0, 1'b1);
    send_req(32'h61626300, 3'd3, 1'b1);
    send_req(32'hffffffff, 3'd4, 1'b1);
    send_req(32'hdeadbeef, 3'd7, 1'b1);
    // Short word not final, then a final word with count above four
    send_req(32'h12345678, 3'd2, 1'b0);
    send_req(32'hffffffff, 3'd5, 1'b1);
    // Bytes past the count must be masked off
    send_req(32'hffffffff, 3'd1, 1'b1);
    // 58-byte message: length no longer fits, needs an extra block
    for (int i = 0; i < 14; i++) send_req($urandom, FULL_WORD_BYTES, 1'b0);
    send_req(32'haabbccdd, 3'd2, 1'b1);

    // Random messages, half of them ending near a block boundary
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 1) == 0) full_words = $urandom_range(0, 20);
      else full_words = 16 * $urandom_range(0, 2) + $urandom_range(13, 16);
      send_message(full_words, 3'($urandom_range(0, 7)));
      words_sent += full_words + 1;
    end
    in_valid <= 1'b0;

    // Drain the digest queue, then watch for stray words
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
